// ===== hw/rtl/dhld_pkg.sv =====
// Package for the dual-header length deframer.
// Shared result type, phase encoding and header constants; no dependencies.
package dhld_pkg;

    // Frame parser phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    // Header style codes
    localparam logic STYLE_SHORT = 1'b0;  // four-byte header, 16-bit length
    localparam logic STYLE_LONG  = 1'b1;  // five-byte header, 32-bit length

    // Header opener limits
    localparam logic [7:0] SHORT_OPEN_MIN = 8'h80;
    localparam logic [7:0] LONG_OPEN_MAX  = 8'h05;

    // Header byte positions
    localparam logic [2:0] HPOS_FIRST  = 3'd1;
    localparam logic [2:0] HPOS_LEN0   = 3'd2;
    localparam logic [2:0] HPOS_LEN1   = 3'd3;
    localparam logic [2:0] HPOS_LONG_LAST = 3'd4;

    // Output buffer depth
    localparam int OBUF_DEPTH = 2;

    // One deframed result
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_style;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       empty_frame;
    } result_t;

endpackage

// ===== hw/rtl/dual_header_length_deframer.sv =====
// Top level of the dual-header length deframer.
// Depends on dhld_pkg, dhld_parse and dhld_obuf.
//
//  channel   direction  tdata               tuser                              tlast
//  s_axis    in         [7:0] data_byte     -                                  -
//  m_axis    out        [7:0] payload_byte  [0] style [1] first [2] empty      last_of_frame
//
// One byte is taken per cycle while s_axis_tready is high; a taken byte passes the input register,
// then its result is registered in the result buffer before it appears on m_axis.
// The parser does all of its work for a byte between the input register and the buffer.
// Reset clears the parser to hunting and empties both stages.
// When m_axis stalls, up to two results are held and one more byte waits in the input
// register before s_axis_tready drops.
module dual_header_length_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]  m_axis_tuser,   // [0] frame_style, [1] first_of_frame, [2] empty_frame
    output logic        m_axis_tlast
);
    import dhld_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        step;
    logic        has_space;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    assign step          = in_valid_reg && has_space;
    assign s_axis_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    // Frame parser
    dhld_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result buffer
    dhld_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_space (has_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    // Output packing
    assign m_axis_tdata = out_res.payload_byte;
    assign m_axis_tuser = {out_res.empty_frame, out_res.first_of_frame, out_res.frame_style};
    assign m_axis_tlast = out_res.last_of_frame;

endmodule

// ===== hw/rtl/dhld_parse.sv =====
// Frame parser: header hunt, length capture and payload count.
// Depends on dhld_pkg. Advances one byte whenever step is high.
module dhld_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    output logic               res_valid,
    output dhld_pkg::result_t  res
);
    import dhld_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [2:0]   hpos_reg, hpos_next;
    logic         style_reg, style_next;
    logic [31:0]  len_reg, len_next;
    logic [31:0]  remain_reg, remain_next;
    logic         first_reg, first_next;

    // Header decode shared by both combinational blocks
    logic         hdr_done;
    logic [31:0]  len_upd;
    logic         is_short_open;
    logic         is_long_open;
    logic         last_payload;

    assign is_short_open = (data_byte >= SHORT_OPEN_MIN);
    assign is_long_open  = (data_byte <= LONG_OPEN_MAX);
    assign last_payload  = (remain_reg <= 32'd1);

    // Length assembly for the current header byte
    always_comb
    begin
        len_upd  = len_reg;
        hdr_done = 1'b0;
        if (style_reg == STYLE_SHORT)
        begin
            if (hpos_reg == HPOS_LEN0)
            begin
                len_upd = {24'd0, data_byte};
            end
            else if (hpos_reg == HPOS_LEN1)
            begin
                len_upd  = len_reg | {16'd0, data_byte, 8'd0};
                hdr_done = 1'b1;
            end
        end
        else
        begin
            unique case (hpos_reg)
                3'd1:    len_upd = len_reg | {24'd0, data_byte};
                3'd2:    len_upd = len_reg | {16'd0, data_byte, 8'd0};
                3'd3:    len_upd = len_reg | {8'd0, data_byte, 16'd0};
                3'd4:    len_upd = len_reg | {data_byte, 24'd0};
                default: len_upd = len_reg;
            endcase
            hdr_done = (hpos_reg >= HPOS_LONG_LAST);
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hdr_done)
                    phase_next = (len_upd == 32'd0) ? PH_HUNT : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (last_payload)
                    phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (is_short_open || is_long_open) ? PH_HEADER : PH_HUNT;
            end
        endcase
    end

    // Datapath next values and result
    always_comb
    begin
        hpos_next   = hpos_reg;
        style_next  = style_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        first_next  = first_reg;
        res_valid   = 1'b0;
        res         = '{payload_byte: 8'd0, frame_style: style_reg,
                        first_of_frame: 1'b0, last_of_frame: 1'b0, empty_frame: 1'b0};
        unique case (phase_reg)
            PH_HEADER:
            begin
                len_next = len_upd;
                if (!hdr_done)
                begin
                    hpos_next = hpos_reg + 3'd1;
                end
                else
                begin
                    hpos_next = 3'd0;
                    if (len_upd == 32'd0)
                    begin
                        // zero-length frame: one empty marker result
                        res_valid          = 1'b1;
                        res.first_of_frame = 1'b1;
                        res.last_of_frame  = 1'b1;
                        res.empty_frame    = 1'b1;
                    end
                    else
                    begin
                        remain_next = len_upd;
                        first_next  = 1'b1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid          = 1'b1;
                res.payload_byte   = data_byte;
                res.first_of_frame = first_reg;
                res.last_of_frame  = last_payload;
                first_next         = 1'b0;
                if (remain_reg != 32'd0)
                    remain_next = remain_reg - 32'd1;
            end
            default:
            begin
                // hunting: open a header or drop the byte
                if (is_short_open || is_long_open)
                begin
                    style_next = is_short_open ? STYLE_SHORT : STYLE_LONG;
                    len_next   = 32'd0;
                    hpos_next  = HPOS_FIRST;
                end
            end
        endcase
        res_valid = res_valid & step;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            hpos_reg   <= 3'd0;
            style_reg  <= 1'b0;
            len_reg    <= 32'd0;
            remain_reg <= 32'd0;
            first_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            style_reg  <= style_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            first_reg  <= first_next;
        end
    end

endmodule

// ===== hw/rtl/dhld_obuf.sv =====
// Two-entry result buffer between the parser and the output stream.
// Depends on dhld_pkg.
module dhld_obuf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dhld_pkg::result_t  push_data,
    output logic               has_space,
    output logic               out_valid,
    input  logic               out_ready,
    output dhld_pkg::result_t  out_data
);
    import dhld_pkg::*;

    localparam int CNT_W = $clog2(OBUF_DEPTH + 1);
    localparam int PTR_W = $clog2(OBUF_DEPTH);

    result_t           mem_reg [OBUF_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign has_space = (count_reg < CNT_W'(OBUF_DEPTH));
    assign out_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/dhld_checker.sv =====
// Port-level checks for the dual-header length deframer, bound to the top level.
// Depends on dual_header_length_deframer only through its ports.
module dhld_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);
    logic mid_frame_reg;
    logic style_reg;

    // Track whether a frame is open on the output side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_frame_reg <= 1'b0;
            style_reg     <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            mid_frame_reg <= !m_axis_tlast;
            style_reg     <= m_axis_tuser[0];
        end
    end

    // A stalled request holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    // An empty frame is a single zero request with both marks
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[1] && m_axis_tlast && (m_axis_tdata == 8'd0) && !mid_frame_reg)
        else $error("malformed empty frame");

    // First mark appears exactly when no frame is open
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1] == !mid_frame_reg))
        else $error("first mark out of place");

    // Header style stays fixed within a frame
    a_style: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && mid_frame_reg |-> (m_axis_tuser[0] == style_reg))
        else $error("frame style changed inside a frame");

endmodule

bind dual_header_length_deframer dhld_checker u_dhld_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/dual_header_length_deframer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dual_header_length_deframer: a byte stream of
// length-prefixed frames goes in, payload results are checked against a predictor.
// Depends on dhld_pkg and the deframer RTL.
module dual_header_length_deframer_tb;

    import dhld_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int TARGET_BYTES = 1150;
    localparam int HOLD_START   = 150;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    // Bytes still to send and results still owed by the block
    logic [7:0] stream_bytes[$];
    result_t    expected_results[$];
    int         total_bytes;

    // Predictor copy of the parser state
    phase_t      frame_phase    = PH_HUNT;
    logic [2:0]  hdr_pos        = '0;
    logic        cur_style      = STYLE_SHORT;
    logic [31:0] len_acc        = '0;
    logic [31:0] payload_left   = '0;
    logic        next_is_first  = 1'b0;

    // Run bookkeeping
    int sent_count     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    logic hold_done    = 1'b0;
    int error_count    = 0;
    int results_seen   = 0;
    int frames_closed  = 0;
    int empty_frames   = 0;

    dual_header_length_deframer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Advance the frame parser by one byte and queue any result it owes
    function automatic void deframe_byte(input logic [7:0] b);
        logic    hdr_done;
        result_t res;
        hdr_done = 1'b0;
        res      = '0;
        case (frame_phase)
            PH_HEADER:
            begin
                if (cur_style == STYLE_SHORT)
                begin
                    if (hdr_pos == HPOS_LEN0)
                        len_acc = {24'h0, b};
                    else if (hdr_pos == HPOS_LEN1)
                    begin
                        len_acc  = len_acc | ({24'h0, b} << 8);
                        hdr_done = 1'b1;
                    end
                end
                else
                begin
                    if (hdr_pos >= HPOS_FIRST && hdr_pos <= HPOS_LONG_LAST)
                        len_acc = len_acc | ({24'h0, b} << (8 * (int'(hdr_pos) - 1)));
                    if (hdr_pos >= HPOS_LONG_LAST)
                        hdr_done = 1'b1;
                end
                if (!hdr_done)
                    hdr_pos = hdr_pos + 3'd1;
                else
                begin
                    hdr_pos = '0;
                    if (len_acc == 32'd0)
                    begin
                        // header announced no payload: one empty marker
                        frame_phase        = PH_HUNT;
                        res.frame_style    = cur_style;
                        res.first_of_frame = 1'b1;
                        res.last_of_frame  = 1'b1;
                        res.empty_frame    = 1'b1;
                        expected_results.push_back(res);
                    end
                    else
                    begin
                        payload_left  = len_acc;
                        next_is_first = 1'b1;
                        frame_phase   = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res.payload_byte   = b;
                res.frame_style    = cur_style;
                res.first_of_frame = next_is_first;
                res.last_of_frame  = (payload_left <= 32'd1);
                expected_results.push_back(res);
                next_is_first = 1'b0;
                if (payload_left != 32'd0)
                    payload_left = payload_left - 32'd1;
                if (res.last_of_frame)
                    frame_phase = PH_HUNT;
            end
            default:
            begin
                // hunting: only opener bytes start a header, the rest is dropped
                frame_phase = PH_HUNT;
                if (b >= SHORT_OPEN_MIN || b <= LONG_OPEN_MAX)
                begin
                    cur_style   = (b >= SHORT_OPEN_MIN) ? STYLE_SHORT : STYLE_LONG;
                    len_acc     = '0;
                    hdr_pos     = HPOS_FIRST;
                    frame_phase = PH_HEADER;
                end
            end
        endcase
    endfunction

    // Idle phases by progress: none, sender idle, receiver stalls, both
    function automatic int phase_index();
        return (total_bytes == 0) ? 0 : (sent_count * 4) / total_bytes;
    endfunction

    function automatic int sender_idle_pct();
        case (phase_index())
            1:       return 64;
            3:       return 37;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (phase_index())
            2:       return 64;
            3:       return 37;
            default: return 0;
        endcase
    endfunction

    // Append one frame; payload may stop short of the declared length
    task automatic add_frame(input logic long_hdr, input logic [7:0] opener,
                             input logic [31:0] len, input int n_payload);
        stream_bytes.push_back(opener);
        if (long_hdr)
        begin
            for (int i = 0; i < 4; i++)
                stream_bytes.push_back(len[8*i +: 8]);
        end
        else
        begin
            stream_bytes.push_back(8'($urandom_range(255)));
            stream_bytes.push_back(len[7:0]);
            stream_bytes.push_back(len[15:8]);
        end
        for (int i = 0; i < n_payload; i++)
            stream_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Driver: present the next byte whenever the slot is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata);
                sent_count <= sent_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stream_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= stream_bytes.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off early in the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && sent_count >= HOLD_START)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES - 1;
            hold_done     <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    // Monitor: compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ERROR unexpected result: data=%02h user=%03b last=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                automatic result_t exp_res = expected_results.pop_front();
                results_seen++;
                if (m_axis_tlast)
                    frames_closed++;
                if (m_axis_tuser[2])
                    empty_frames++;
                if (m_axis_tdata !== exp_res.payload_byte)
                begin
                    $display("%0t ERROR payload_byte: expected %02h, actual %02h",
                             $time, exp_res.payload_byte, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[0] !== exp_res.frame_style)
                begin
                    $display("%0t ERROR frame_style: expected %b, actual %b",
                             $time, exp_res.frame_style, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== exp_res.first_of_frame)
                begin
                    $display("%0t ERROR first_of_frame: expected %b, actual %b",
                             $time, exp_res.first_of_frame, m_axis_tuser[1]);
                    error_count++;
                end
                if (m_axis_tlast !== exp_res.last_of_frame)
                begin
                    $display("%0t ERROR last_of_frame: expected %b, actual %b",
                             $time, exp_res.last_of_frame, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser[2] !== exp_res.empty_frame)
                begin
                    $display("%0t ERROR empty_frame: expected %b, actual %b",
                             $time, exp_res.empty_frame, m_axis_tuser[2]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles, %0d results still owed",
                     $time, cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus build, reset, and end of run
    initial
    begin
        logic [7:0]  directed[];
        int          useful_bytes;
        int          pick;
        int          n_noise;
        logic        long_hdr;
        logic [31:0] frame_len;

        directed = '{
            // long header, zero length: empty marker
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            // short header, one payload byte
            8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00,
            // stray bytes at both ends of the dropped range
            8'h06, 8'h7F,
            // long header at the top opener, two payload bytes
            8'h05, 8'h02, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hA5,
            // short header at the lowest opener, zero length
            8'h80, 8'h5A, 8'h00, 8'h00
        };

        foreach (directed[i])
            stream_bytes.push_back(directed[i]);

        // Random part: mostly well-formed frames, some stray noise between them
        useful_bytes = 0;
        while (useful_bytes < TARGET_BYTES)
        begin
            if ($urandom_range(99) < 15)
            begin
                n_noise = $urandom_range(1, 4);
                for (int i = 0; i < n_noise; i++)
                    stream_bytes.push_back(8'($urandom_range(8'h06, 8'h7F)));
            end
            else
            begin
                long_hdr = 1'($urandom_range(1));
                pick     = $urandom_range(99);
                if (pick < 10)
                    frame_len = 32'd0;
                else if (pick < 13)
                    frame_len = 32'd1;
                else if (pick < 16)
                    frame_len = $urandom_range(256, 300);
                else
                    frame_len = $urandom_range(2, 12);
                add_frame(long_hdr,
                          long_hdr ? 8'($urandom_range(LONG_OPEN_MAX))
                                   : 8'($urandom_range(SHORT_OPEN_MIN, 8'hFF)),
                          frame_len, frame_len);
                useful_bytes += (long_hdr ? 5 : 4) + frame_len;
            end
        end

        // Tail: a maximal long-header length, stream ends inside its payload
        add_frame(1'b1, 8'($urandom_range(LONG_OPEN_MAX)), 32'hFFFF_FFFF, 20);
        total_bytes = stream_bytes.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // All requests sent, then all results back, then let the pipe settle
        do
            @(posedge clk);
        while (stream_bytes.size() > 0 || s_axis_tvalid);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d stream bytes, both header styles, strays, and a %0d-cycle hold",
                 total_bytes, HOLD_CYCLES);
        $display("Checked %0d results: %0d frames closed, %0d empty, %0d errors",
                 results_seen, frames_closed, empty_frames, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
